/* src/assert_macros.svh */
// Assertion macros shared by the RTL, clocked on clk with synchronous active-low reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

/* src/lpbc_pkg.sv */
// Package for the LRU page buffer controller: default sizes and stream field widths.
package lpbc_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  // fixed stream field widths
  localparam int OP_W       = 1;
  localparam int PAGE_ID_W  = 16;
  localparam int FRAME_W    = 4;
  localparam int EVPAGE_W   = 16;
  localparam int TOTAL_W    = 32;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 88;

endpackage

/* src/lru_page_buffer_controller.sv */
// LRU page buffer controller: fully associative write-back buffer pool with exact LRU ranks.
//
// Each input transaction is one page access (in_tuser = op, 1 for write; in_tdata = page_id).
// The controller takes one access at a time: after acceptance it walks every frame once through
// the shared tag-compare / rank-compare unit (one frame per cycle, tag RAM read in the cycle
// before its compare), then updates tag, valid, dirty, ranks and counters in the update
// state and returns to idle, where in_tready is high. The result sits in an output register,
// so a new access is accepted and scanned while the previous result waits on out_tready; only
// the update state stalls behind an untaken result. No clearing pass is needed after reset.
`include "assert_macros.svh"

module lru_page_buffer_controller #(
  parameter int FRAMES    = lpbc_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lpbc_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: page_id[15:0]
  input  logic [lpbc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: op[0]
  input  logic [lpbc_pkg::OP_W-1:0]         in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: hit[0], frame[4:1], fetch[5], evict_dirty[6], evict_page[22:7],
  //            hit_total[54:23], io_total[86:55], zero pad[87]
  output logic [lpbc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready
);

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]           state_r;
  logic [CW-1:0]        cnt_r;
  logic [FW-1:0]        eidx_r;
  logic                 op_r;
  logic [PAGE_BITS-1:0] page_r;

  logic [PAGE_BITS-1:0] tag_mem [FRAMES];
  logic [PAGE_BITS-1:0] tag_rd_r;

  logic [FRAMES-1:0]    valid_r;
  logic [FRAMES-1:0]    dirty_r;
  logic [FW-1:0]        rank_r [FRAMES];

  logic                 found_r;
  logic [FW-1:0]        hit_idx_r;
  logic [FW-1:0]        hit_rank_r;
  logic                 free_r;
  logic [FW-1:0]        free_idx_r;
  logic [FW-1:0]        best_idx_r;
  logic [FW-1:0]        best_rank_r;
  logic [PAGE_BITS-1:0] best_tag_r;
  logic                 best_dirty_r;

  logic [lpbc_pkg::TOTAL_W-1:0] hit_cnt_r;
  logic [lpbc_pkg::TOTAL_W-1:0] io_cnt_r;

  logic                           out_valid_r;
  logic                           out_hit_r;
  logic [lpbc_pkg::FRAME_W-1:0]   out_frame_r;
  logic                           out_fetch_r;
  logic                           out_evict_r;
  logic [lpbc_pkg::EVPAGE_W-1:0]  out_evpage_r;
  logic [lpbc_pkg::TOTAL_W-1:0]   out_hit_tot_r;
  logic [lpbc_pkg::TOTAL_W-1:0]   out_io_tot_r;

  logic                 in_acc;
  logic                 eval_en;
  logic                 tag_match;
  logic [FW-1:0]        rank_e;
  logic                 upd_go;
  logic [FW-1:0]        f_w;
  logic [FW:0]          old_rank_w;
  logic                 victim_w;
  logic                 evict_w;
  logic                 fetch_w;
  logic [lpbc_pkg::TOTAL_W-1:0] hit_nxt;
  logic [lpbc_pkg::TOTAL_W-1:0] io_nxt;

  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // shared compare unit: one frame per cycle, tag RAM data arrives in the cycle after its address
  assign eval_en   = (state_r == ST_SCAN) && (cnt_r != '0);
  assign rank_e    = rank_r[eidx_r];
  assign tag_match = valid_r[eidx_r] && (tag_rd_r == page_r);

  assign upd_go     = (state_r == ST_UPD) && (!out_valid_r || out_tready);
  assign victim_w   = !found_r && !free_r;
  assign f_w        = found_r ? hit_idx_r : (free_r ? free_idx_r : best_idx_r);
  assign old_rank_w = found_r ? {1'b0, hit_rank_r} :
                      (free_r ? (FW+1)'(FRAMES) : {1'b0, best_rank_r});
  assign evict_w    = victim_w && best_dirty_r;
  assign fetch_w    = !found_r && !op_r;
  assign hit_nxt    = hit_cnt_r + lpbc_pkg::TOTAL_W'(found_r);
  assign io_nxt     = io_cnt_r + lpbc_pkg::TOTAL_W'(evict_w) + lpbc_pkg::TOTAL_W'(fetch_w);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_SCAN;
            cnt_r   <= '0;
          end
        end
        ST_SCAN: begin
          if (cnt_r == CW'(FRAMES)) begin
            state_r <= ST_UPD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_UPD: begin
          if (upd_go) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // request latch and evaluated index
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_tuser[0];
      page_r <= PAGE_BITS'(in_tdata[lpbc_pkg::PAGE_ID_W-1:0]);
    end
    eidx_r <= cnt_r[FW-1:0];
  end

  // tag RAM: written on install, read by the scan
  always_ff @(posedge clk) begin
    if (upd_go && !found_r) begin
      tag_mem[f_w] <= page_r;
    end
    tag_rd_r <= tag_mem[cnt_r[FW-1:0]];
  end

  // scan results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      free_r  <= 1'b0;
    end else if (in_acc) begin
      found_r <= 1'b0;
      free_r  <= 1'b0;
    end else if (eval_en) begin
      if (tag_match && !found_r) begin
        found_r    <= 1'b1;
        hit_idx_r  <= eidx_r;
        hit_rank_r <= rank_e;
      end
      if (!valid_r[eidx_r] && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= eidx_r;
      end
      // oldest frame, lowest index on a tie
      if (cnt_r == CW'(1) || rank_e > best_rank_r) begin
        best_idx_r   <= eidx_r;
        best_rank_r  <= rank_e;
        best_tag_r   <= tag_rd_r;
        best_dirty_r <= dirty_r[eidx_r];
      end
    end
  end

  // frame state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      dirty_r   <= '0;
      hit_cnt_r <= '0;
      io_cnt_r  <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (upd_go) begin
      hit_cnt_r <= hit_nxt;
      io_cnt_r  <= io_nxt;
      if (found_r) begin
        if (op_r) begin
          dirty_r[f_w] <= 1'b1;
        end
      end else begin
        valid_r[f_w] <= 1'b1;
        dirty_r[f_w] <= op_r;
      end
      for (int i = 0; i < FRAMES; i++) begin
        if (FW'(i) == f_w) begin
          rank_r[i] <= '0;
        end else if (valid_r[i] && ({1'b0, rank_r[i]} < old_rank_w)) begin
          rank_r[i] <= rank_r[i] + 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_hit_r     <= found_r;
      out_frame_r   <= lpbc_pkg::FRAME_W'(f_w);
      out_fetch_r   <= fetch_w;
      out_evict_r   <= evict_w;
      out_evpage_r  <= evict_w ? lpbc_pkg::EVPAGE_W'(best_tag_r) : '0;
      out_hit_tot_r <= hit_nxt;
      out_io_tot_r  <= io_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_io_tot_r, out_hit_tot_r, out_evpage_r,
                       out_evict_r, out_fetch_r, out_frame_r, out_hit_r};

  `ASSERT_CLK(a_hit_frame_valid, (upd_go && found_r) |-> valid_r[hit_idx_r], "hit on invalid frame")
  `ASSERT_CLK(a_evict_only_full, (upd_go && evict_w) |-> (&valid_r), "eviction with a free frame")
  `ASSERT_CLK(a_mru_rank_zero, upd_go |=> (rank_r[$past(f_w)] == '0), "accessed frame not MRU")
  `ASSERT_NEVER(a_hit_no_io, out_valid_r && out_hit_r && (out_fetch_r || out_evict_r), "disk op on hit")

endmodule

/* tb/sv/tb_top.sv */
// Self-checking stream testbench for the LRU page buffer controller.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 380;
  localparam int HOLD_AT    = 150;
  localparam int HOLD_LEN   = 400;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 40;

  typedef struct {
    logic                           wr;
    logic [lpbc_pkg::PAGE_ID_W-1:0] page;
  } page_access_t;

  typedef struct packed {
    logic                          hit;
    logic [lpbc_pkg::FRAME_W-1:0]  frame;
    logic                          fetch;
    logic                          evict_dirty;
    logic [lpbc_pkg::EVPAGE_W-1:0] evict_page;
    logic [lpbc_pkg::TOTAL_W-1:0]  hit_total;
    logic [lpbc_pkg::TOTAL_W-1:0]  io_total;
  } access_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic [lpbc_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [lpbc_pkg::OP_W-1:0]        in_tuser = '0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [lpbc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;

  lru_page_buffer_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  page_access_t   access_q[$];
  access_result_t pending_results[$];
  int             total_accesses;
  int             accesses_taken = 0;
  int             error_count = 0;
  int             hold_left = 0;
  bit             hold_done = 1'b0;
  int             quiet_cycles = 0;

  // shadow of the buffer pool
  logic [lpbc_pkg::PAGE_ID_W-1:0] pool_tag   [lpbc_pkg::FRAMES_DEF];
  bit                             pool_valid [lpbc_pkg::FRAMES_DEF];
  bit                             pool_dirty [lpbc_pkg::FRAMES_DEF];
  int                             pool_rank  [lpbc_pkg::FRAMES_DEF];
  logic [lpbc_pkg::TOTAL_W-1:0]   hit_count = '0;
  logic [lpbc_pkg::TOTAL_W-1:0]   io_count = '0;

  initial begin
    for (int i = 0; i < lpbc_pkg::FRAMES_DEF; i++) begin
      pool_tag[i]   = '0;
      pool_valid[i] = 1'b0;
      pool_dirty[i] = 1'b0;
      pool_rank[i]  = 0;
    end
  end

  initial forever #10 clk = ~clk;

  // frame f becomes MRU; valid frames younger than old_rank age by one
  task automatic promote_frame(input int f, input int old_rank);
    for (int i = 0; i < lpbc_pkg::FRAMES_DEF; i++) begin
      if (i != f && pool_valid[i] && pool_rank[i] < old_rank) pool_rank[i]++;
    end
    pool_rank[f] = 0;
  endtask

  task automatic lru_access(input logic wr, input logic [lpbc_pkg::PAGE_ID_W-1:0] page,
                            output access_result_t r);
    int f;
    int old_rank;
    bit found;
    bit have_free;
    f = 0;
    found = 1'b0;
    have_free = 1'b0;
    r = '0;
    for (int i = 0; i < lpbc_pkg::FRAMES_DEF; i++) begin
      if (!found && pool_valid[i] && pool_tag[i] == page) begin
        f = i;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      hit_count++;
      if (wr) pool_dirty[f] = 1'b1;
      promote_frame(f, pool_rank[f]);
    end else begin
      old_rank = lpbc_pkg::FRAMES_DEF;
      for (int i = 0; i < lpbc_pkg::FRAMES_DEF; i++) begin
        if (!have_free && !pool_valid[i]) begin
          f = i;
          have_free = 1'b1;
        end
      end
      if (!have_free) begin
        // victim: lowest-indexed frame of highest rank
        f = 0;
        for (int i = 1; i < lpbc_pkg::FRAMES_DEF; i++) begin
          if (pool_rank[i] > pool_rank[f]) f = i;
        end
        old_rank = pool_rank[f];
        if (pool_dirty[f]) begin
          r.evict_dirty = 1'b1;
          r.evict_page  = pool_tag[f];
          io_count++;
        end
      end
      pool_tag[f]   = page;
      pool_valid[f] = 1'b1;
      pool_dirty[f] = wr;
      promote_frame(f, old_rank);
      if (!wr) begin
        r.fetch = 1'b1;
        io_count++;
      end
    end
    r.frame     = f[lpbc_pkg::FRAME_W-1:0];
    r.hit_total = hit_count;
    r.io_total  = io_count;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  function automatic int idle_pct(input bit sender);
    int phase;
    phase = (total_accesses == 0) ? 2 : accesses_taken * 3 / total_accesses;
    if (phase == 0) return sender ? 20 : 54;
    if (phase == 1) return sender ? 54 : 20;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    access_result_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        lru_access(in_tuser[0], in_tdata, r);
        pending_results.push_back(r);
        accesses_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (access_q.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= access_q[0].page;
          in_tuser  <= access_q[0].wr;
          access_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the controller backs up into its input
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && accesses_taken >= HOLD_AT) begin
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[31:0], '0);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[0] !== want.hit)
            report_mismatch("hit", 32'(out_tdata[0]), 32'(want.hit));
          if (out_tdata[4:1] !== want.frame)
            report_mismatch("frame", 32'(out_tdata[4:1]), 32'(want.frame));
          if (out_tdata[5] !== want.fetch)
            report_mismatch("fetch", 32'(out_tdata[5]), 32'(want.fetch));
          if (out_tdata[6] !== want.evict_dirty)
            report_mismatch("evict_dirty", 32'(out_tdata[6]), 32'(want.evict_dirty));
          if (out_tdata[22:7] !== want.evict_page)
            report_mismatch("evict_page", 32'(out_tdata[22:7]), 32'(want.evict_page));
          if (out_tdata[54:23] !== want.hit_total)
            report_mismatch("hit_total", out_tdata[54:23], want.hit_total);
          if (out_tdata[86:55] !== want.io_total)
            report_mismatch("io_total", out_tdata[86:55], want.io_total);
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("lru_page_buffer_controller test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_access(input logic wr, input logic [lpbc_pkg::PAGE_ID_W-1:0] page);
    page_access_t a;
    a.wr   = wr;
    a.page = page;
    access_q.push_back(a);
  endtask

  initial begin
    logic [lpbc_pkg::PAGE_ID_W-1:0] working_set [20];
    // directed: read/write misses, hits, fill, dirty and clean eviction
    queue_access(1'b0, 16'h0000);
    queue_access(1'b1, 16'hFFFF);
    queue_access(1'b0, 16'h0000);
    queue_access(1'b1, 16'h0000);
    for (int k = 1; k <= 14; k++)
      queue_access(k[0], 16'h1000 * k[15:0] + k[15:0]);
    queue_access(1'b0, 16'h5555);   // evicts the dirty 0xFFFF
    queue_access(1'b0, 16'hAAAA);   // evicts a dirty page
    queue_access(1'b1, 16'h1234);   // write miss over another dirty victim
    queue_access(1'b0, 16'h0000);   // read miss over a clean victim
    // random: mostly a small working set so hits and evictions stay frequent
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) begin
        for (int j = 0; j < 20; j++) working_set[j] = 16'($urandom_range(16'hFFFF));
      end
      if ($urandom_range(99) < 85)
        queue_access(1'($urandom_range(1)), working_set[$urandom_range(19)]);
      else
        queue_access(1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
    end
    total_accesses = access_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (access_q.size() > 0 || in_tvalid) @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() > 0)
      report_mismatch("missing results", pending_results.size(), 0);
    if (error_count == 0) begin
      $display("lru_page_buffer_controller test passed");
    end else begin
      $display("lru_page_buffer_controller test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/lpbc_pkg.sv
src/lru_page_buffer_controller.sv
tb/sv/tb_top.sv
